// ===== rtl/charlieplex_pwm_led_scanner_macros.svh =====
// assertion helpers used by the checker file
`ifndef CHARLIEPLEX_PWM_LED_SCANNER_MACROS_SVH
`define CHARLIEPLEX_PWM_LED_SCANNER_MACROS_SVH

// clocked assertion that is switched off while reset is high
`define CPX_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define CPX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cpx_pkg.sv =====
package cpx_pkg;

   // input item codes
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_PIXEL = 2'd0;
   localparam opcode_type OP_RGB   = 2'd1;
   localparam opcode_type OP_TICK  = 2'd2;
   localparam opcode_type OP_NOP   = 2'd3;

   // register indexes of the csr port
   localparam int CSR_IDX_W = 2;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_MAX_BRIGHTNESS  = 2'd0;
   localparam csr_idx_type REG_COLUMN_IS_ANODE = 2'd1;
   localparam int CSR_DATA_W = 8;

   // payload widths
   localparam int COORD_W = 4;
   localparam int LEVEL_W = 8;
   localparam int RGB_W   = 24;
   localparam int PIN_OUT_W = 4;

   typedef struct packed {
      logic [PIN_OUT_W-1:0] anode_pin;
      logic [PIN_OUT_W-1:0] cathode_pin;
      logic                 drive_on;
      logic                 pair_done;
   } rsp_type;

endpackage

// ===== rtl/cpx_req_if.sv =====
interface cpx_req_if;
   logic                               valid;
   logic                               ready;
   cpx_pkg::opcode_type                opcode;
   logic [cpx_pkg::COORD_W-1:0]        pos_x;
   logic [cpx_pkg::COORD_W-1:0]        pos_y;
   logic [cpx_pkg::LEVEL_W-1:0]        level;
   logic [cpx_pkg::RGB_W-1:0]          rgb_color;

   modport source (output valid, opcode, pos_x, pos_y, level, rgb_color, input ready);
   modport sink (input valid, opcode, pos_x, pos_y, level, rgb_color, output ready);
endinterface

// ===== rtl/cpx_rsp_if.sv =====
interface cpx_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [cpx_pkg::PIN_OUT_W-1:0]     anode_pin;
   logic [cpx_pkg::PIN_OUT_W-1:0]     cathode_pin;
   logic                              drive_on;
   logic                              pair_done;

   modport source (output valid, anode_pin, cathode_pin, drive_on, pair_done, input ready);
   modport sink (input valid, anode_pin, cathode_pin, drive_on, pair_done, output ready);
endinterface

// ===== rtl/cpx_csr_if.sv =====
interface cpx_csr_if;
   logic                               valid;
   logic                               ready;
   cpx_pkg::csr_idx_type               index;
   logic [cpx_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/cpx_ram.sv =====
module cpx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/charlieplex_pwm_led_scanner.sv =====
// a tick's result goes from the work stage through the store read into the output queue
// throughput: one pixel write per cycle while req ready is high; a tick
//    only issues while the read stage and the output queue together hold fewer than two
// a mapped rgb write is made of three byte writes through the single store write port
// reset: synchronous; after reset all PIN_COUNT*PIN_COUNT entries of the pixel store (256 at
//    16 pins) are zeroed one entry a cycle, with req ready low; csr writes are taken
module charlieplex_pwm_led_scanner #(
   parameter int PIN_COUNT = 16
) (
   input  logic            clock,
   input  logic            reset,
   cpx_req_if.sink         req_ch,
   cpx_rsp_if.source       rsp_ch,
   cpx_csr_if.sink         csr_ch
);

   localparam int DEPTH  = PIN_COUNT * PIN_COUNT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PIN_W  = $clog2(PIN_COUNT);
   localparam int PINX_W = PIN_W + 1;
   localparam int PX_W   = cpx_pkg::COORD_W + 1;

   // configuration registers
   logic [cpx_pkg::LEVEL_W-1:0] max_bright_ff;
   logic                        col_anode_ff;

   // clearing pass over the pixel store
   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // work stage: the accepted item
   logic                          a_valid_ff;
   cpx_pkg::opcode_type           a_op_ff;
   logic [cpx_pkg::COORD_W-1:0]   a_x_ff;
   logic [cpx_pkg::COORD_W-1:0]   a_y_ff;
   logic [cpx_pkg::LEVEL_W-1:0]   a_level_ff;
   logic [cpx_pkg::RGB_W-1:0]     a_rgb_ff;
   logic [1:0]                    a_sub_ff;

   // scan and pwm state
   logic [PIN_W-1:0]            scan_row_ff, scan_row_in;
   logic [PIN_W-1:0]            scan_col_ff, scan_col_in;
   logic [cpx_pkg::LEVEL_W-1:0] pwm_ff;

   // read stage: tick waiting for store data
   logic                          b_valid_ff;
   logic [cpx_pkg::PIN_OUT_W-1:0] b_anode_ff;
   logic [cpx_pkg::PIN_OUT_W-1:0] b_cathode_ff;
   logic [cpx_pkg::LEVEL_W-1:0]   b_pwm_ff;
   logic                          b_done_ff;

   // two-entry output queue
   logic             q0_valid_ff, q1_valid_ff;
   cpx_pkg::rsp_type q0_ff, q1_ff;

   // store ports
   logic                        ram_we;
   logic [ADDR_W-1:0]           ram_waddr;
   logic [cpx_pkg::LEVEL_W-1:0] ram_wdata;
   logic                        ram_re;
   logic [ADDR_W-1:0]           ram_raddr;
   logic [cpx_pkg::LEVEL_W-1:0] ram_rdata;

   logic a_done;
   logic tick_issue;
   logic pop;
   logic [1:0] occupancy;
   cpx_pkg::rsp_type push_rsp;

   // ---------------------------------------------------------------
   // configuration: always ready, unknown indexes are dropped
   // ---------------------------------------------------------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bright_ff <= '1;
         col_anode_ff  <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            cpx_pkg::REG_MAX_BRIGHTNESS:  max_bright_ff <= csr_ch.data;
            cpx_pkg::REG_COLUMN_IS_ANODE: col_anode_ff  <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // write path shared by pixel writes and the three rgb bytes
   // ---------------------------------------------------------------
   logic                        rgb_skip;
   logic [1:0]                  rgb_col;
   logic [cpx_pkg::COORD_W-1:0] rgb_row;
   logic [PX_W-1:0]             px_x;
   logic [cpx_pkg::COORD_W-1:0] px_y;
   logic [PX_W-1:0]             px_c;
   logic [cpx_pkg::LEVEL_W-1:0] px_val;
   logic                        px_ok;

   always_comb begin
      // corners of the 8x8 grid and anything past 7 are dropped
      rgb_skip = ((a_x_ff == 4'd0 || a_x_ff == 4'd7) && (a_y_ff == 4'd0 || a_y_ff == 4'd7))
                 || a_x_ff[3] || a_y_ff[3];
      // grid columns 4..7 fold onto columns 0..3 of rows y+8
      rgb_col = a_x_ff[1:0];
      rgb_row = {a_x_ff[2], a_y_ff[2:0]};

      if (a_op_ff == cpx_pkg::OP_RGB) begin
         px_x = PX_W'({3'b000, rgb_col} * 5'd3) + PX_W'(a_sub_ff);
         px_y = rgb_row;
         unique case (a_sub_ff)
            2'd0:    px_val = a_rgb_ff[23:16];
            2'd1:    px_val = a_rgb_ff[15:8];
            default: px_val = a_rgb_ff[7:0];
         endcase
      end else begin
         px_x   = {1'b0, a_x_ff};
         px_y   = a_y_ff;
         px_val = a_level_ff;
      end

      // skip the diagonal: columns at or past the row move up by one
      px_c  = (px_x >= {1'b0, px_y}) ? px_x + PX_W'(1) : px_x;
      px_ok = (int'(px_y) < PIN_COUNT) && (int'(px_c) < PIN_COUNT);
   end

   // ---------------------------------------------------------------
   // work stage control
   // ---------------------------------------------------------------
   assign occupancy  = 2'(q0_valid_ff) + 2'(q1_valid_ff) + 2'(b_valid_ff);
   assign tick_issue = a_valid_ff && (a_op_ff == cpx_pkg::OP_TICK) && (occupancy < 2'd2);

   always_comb begin
      unique case (a_op_ff)
         cpx_pkg::OP_RGB:  a_done = (a_sub_ff == 2'd2);
         cpx_pkg::OP_TICK: a_done = tick_issue;
         default:          a_done = 1'b1;
      endcase
   end

   assign req_ch.ready = !clearing_ff && (!a_valid_ff || a_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_sub_ff   <= 2'd0;
      end else if (req_ch.valid && req_ch.ready) begin
         a_valid_ff <= 1'b1;
         a_sub_ff   <= 2'd0;
      end else if (a_valid_ff && a_done) begin
         a_valid_ff <= 1'b0;
         a_sub_ff   <= 2'd0;
      end else if (a_valid_ff && a_op_ff == cpx_pkg::OP_RGB) begin
         a_sub_ff <= a_sub_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         a_op_ff    <= req_ch.opcode;
         a_x_ff     <= req_ch.pos_x;
         a_y_ff     <= req_ch.pos_y;
         a_level_ff <= req_ch.level;
         a_rgb_ff   <= req_ch.rgb_color;
      end
   end

   // ---------------------------------------------------------------
   // clearing pass after reset
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (int'(clr_addr_ff) == DEPTH - 1) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // store write port: clearing pass or the work stage
   always_comb begin
      if (clearing_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = a_valid_ff && px_ok &&
                     ((a_op_ff == cpx_pkg::OP_PIXEL) || (a_op_ff == cpx_pkg::OP_RGB && !rgb_skip));
         ram_waddr = ADDR_W'(int'(px_y) * PIN_COUNT + int'(px_c));
         ram_wdata = px_val;
      end
   end

   // reads and writes leave the same stage in order, so a tick always sees earlier writes
   assign ram_re    = tick_issue;
   assign ram_raddr = ADDR_W'(int'(scan_row_ff) * PIN_COUNT + int'(scan_col_ff));

   cpx_ram #(
      .WIDTH (cpx_pkg::LEVEL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------
   // scan advance, never landing on row == column
   // ---------------------------------------------------------------
   logic [PINX_W-1:0] col_step;
   logic [PINX_W-1:0] row_step;
   logic              col_wrap;
   logic              pwm_last;
   logic [PIN_W+cpx_pkg::PIN_OUT_W-1:0] row_ext;
   logic [PIN_W+cpx_pkg::PIN_OUT_W-1:0] col_ext;

   always_comb begin
      col_step = {1'b0, scan_col_ff} + PINX_W'(1);
      if (col_step == {1'b0, scan_row_ff}) begin
         col_step = col_step + PINX_W'(1);
      end
      col_wrap = int'(col_step) >= PIN_COUNT;
      row_step = {1'b0, scan_row_ff} + PINX_W'(1);
      if (int'(row_step) >= PIN_COUNT) begin
         row_step = '0;
      end
      if (col_wrap) begin
         scan_row_in = row_step[PIN_W-1:0];
         scan_col_in = (row_step == '0) ? PIN_W'(1) : '0;
      end else begin
         scan_row_in = scan_row_ff;
         scan_col_in = col_step[PIN_W-1:0];
      end
   end

   // max lowered below the counter mid pair still ends the pair
   assign pwm_last = pwm_ff >= max_bright_ff;

   // pins are reported in their low bits
   assign row_ext = {{cpx_pkg::PIN_OUT_W{1'b0}}, scan_row_ff};
   assign col_ext = {{cpx_pkg::PIN_OUT_W{1'b0}}, scan_col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_row_ff <= '0;
         scan_col_ff <= PIN_W'(1);
         pwm_ff      <= '0;
      end else if (tick_issue) begin
         if (pwm_last) begin
            pwm_ff      <= '0;
            scan_row_ff <= scan_row_in;
            scan_col_ff <= scan_col_in;
         end else begin
            pwm_ff <= pwm_ff + cpx_pkg::LEVEL_W'(1);
         end
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= tick_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_issue) begin
         b_anode_ff   <= col_anode_ff ? col_ext[cpx_pkg::PIN_OUT_W-1:0]
                                      : row_ext[cpx_pkg::PIN_OUT_W-1:0];
         b_cathode_ff <= col_anode_ff ? row_ext[cpx_pkg::PIN_OUT_W-1:0]
                                      : col_ext[cpx_pkg::PIN_OUT_W-1:0];
         b_pwm_ff     <= pwm_ff;
         b_done_ff    <= pwm_last;
      end
   end

   // ---------------------------------------------------------------
   // output queue: a tick is only issued when a slot is sure to be free
   // ---------------------------------------------------------------
   always_comb begin
      push_rsp.anode_pin   = b_anode_ff;
      push_rsp.cathode_pin = b_cathode_ff;
      push_rsp.drive_on    = b_pwm_ff < ram_rdata;
      push_rsp.pair_done   = b_done_ff;
   end

   assign pop = q0_valid_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q0_valid_ff <= 1'b0;
         q1_valid_ff <= 1'b0;
      end else if (pop) begin
         q0_valid_ff <= q1_valid_ff || b_valid_ff;
         q1_valid_ff <= q1_valid_ff && b_valid_ff;
      end else if (b_valid_ff) begin
         q0_valid_ff <= 1'b1;
         q1_valid_ff <= q0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         q0_ff <= q1_valid_ff ? q1_ff : push_rsp;
         if (q1_valid_ff && b_valid_ff) begin
            q1_ff <= push_rsp;
         end
      end else if (b_valid_ff) begin
         if (q0_valid_ff) begin
            q1_ff <= push_rsp;
         end else begin
            q0_ff <= push_rsp;
         end
      end
   end

   assign rsp_ch.valid       = q0_valid_ff;
   assign rsp_ch.anode_pin   = q0_ff.anode_pin;
   assign rsp_ch.cathode_pin = q0_ff.cathode_pin;
   assign rsp_ch.drive_on    = q0_ff.drive_on;
   assign rsp_ch.pair_done   = q0_ff.pair_done;

endmodule

// ===== rtl/cpx_checker.sv =====
`include "charlieplex_pwm_led_scanner_macros.svh"

module cpx_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cpx_pkg::PIN_OUT_W-1:0] anode_pin,
   input logic [cpx_pkg::PIN_OUT_W-1:0] cathode_pin,
   input logic                          drive_on,
   input logic                          pair_done
);

   // store is being zeroed right after reset
   `CPX_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_ready, "ready during clear")

   `CPX_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "result after reset")

   // the scan never visits the diagonal
   `CPX_ASSERT(a_no_diagonal, clock, reset, rsp_valid |-> anode_pin != cathode_pin, "diagonal pair")

   `CPX_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(anode_pin) && $stable(cathode_pin)
         && $stable(drive_on) && $stable(pair_done),
      "result dropped while stalled")

endmodule

bind charlieplex_pwm_led_scanner cpx_checker u_cpx_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .anode_pin   (rsp_ch.anode_pin),
   .cathode_pin (rsp_ch.cathode_pin),
   .drive_on    (rsp_ch.drive_on),
   .pair_done   (rsp_ch.pair_done)
);
